// ----- rtl/pee_pkg.sv -----
// shared types, character codes and classification for the postfix evaluator
`timescale 1ns / 1ps

package pee_pkg;

    localparam int DATA_W  = 32;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_PUSH = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_MUL  = 3'd4,
        OP_DIV  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_DIVZERO   = 2'd3
    } t_status;

    // one classified character as it waits between front and back
    typedef struct packed {
        t_op                op;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_item;

    function automatic t_op classify(input logic [CHAR_W-1:0] c);
        t_op op;
        op = OP_NOP;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            op = OP_PUSH;
        end else if (c == CH_PLUS) begin
            op = OP_ADD;
        end else if (c == CH_MINUS) begin
            op = OP_SUB;
        end else if (c == CH_STAR) begin
            op = OP_MUL;
        end else if (c == CH_SLASH) begin
            op = OP_DIV;
        end
        return op;
    endfunction

endpackage

// ----- rtl/postfix_expression_evaluator.sv -----
// top level of the postfix expression evaluator
`timescale 1ns / 1ps

// Evaluates postfix expressions one character per transfer. Digits push
// their value, + - * / combine the two top operands in 32-bit wrapping
// arithmetic (division truncates toward zero), other characters are
// ignored; the transfer carrying end_of_expr yields one result with a
// status (0 ok, 1 underflow, 2 overflow, 3 divide by zero, value zero on
// error). A two-entry queue separates the input from the execution unit,
// so characters keep being taken, until it is full, while an operation
// runs or a result waits. Ignored characters are dropped at the queue
// unless they carry the end mark. A push is done in the idle state; + - *
// read the stack ram, then operate; / then waits for the divider, one
// quotient bit per cycle; the end mark loads the result register. The
// stack holds STACK_DEPTH operands and needs no clearing after reset.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_char_code,
    input  logic                i_end_of_expr,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_value,
    output logic [1:0]          o_status
);

    pee_pkg::t_item                w_item;
    logic                          w_item_valid;
    logic                          w_pop;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [pee_pkg::DATA_W-1:0]    w_dividend;
    logic [pee_pkg::DATA_W-1:0]    w_divisor;
    logic [pee_pkg::DATA_W-1:0]    w_quot;
    logic [pee_pkg::DATA_W-1:0]    w_value;

    pee_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_code   (i_char_code),
        .i_end_of_expr (i_end_of_expr),
        .o_item        (w_item),
        .o_item_valid  (w_item_valid),
        .i_pop         (w_pop)
    );

    pee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    pee_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .o_div_start  (w_div_start),
        .o_dividend   (w_dividend),
        .o_divisor    (w_divisor),
        .i_div_done   (w_div_done),
        .i_quot       (w_quot),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_value      (w_value),
        .o_status     (o_status)
    );

    assign o_value = $signed(w_value);

`ifndef SYNTH
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != pee_pkg::ST_OK |-> o_value == '0)
        else $error("error result carries a non-zero value");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid)
        else $error("execution unit popped an empty queue");

    a_div_not_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> !w_div_done)
        else $error("divider finished one cycle after start");

    a_no_start_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> !w_div_start)
        else $error("divider restarted while busy");
`endif

endmodule

// ----- rtl/pee_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pee_front.sv -----
// front end: takes characters, classifies them and queues the useful ones
`timescale 1ns / 1ps

module pee_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pee_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_end_of_expr,
    output pee_pkg::t_item              o_item,
    output logic                        o_item_valid,
    input  logic                        i_pop
);

    pee_pkg::t_item r_q [2];
    logic           r_wp, n_wp;
    logic           r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;

    pee_pkg::t_item w_in;
    logic           w_take;
    logic           w_push;
    logic           w_pop;

    assign o_stall      = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        w_in.op    = pee_pkg::classify(i_char_code);
        w_in.digit = i_char_code[pee_pkg::DIGIT_W-1:0];
        w_in.last  = i_end_of_expr;
        w_take     = i_valid && !o_stall;
        // ignored characters are dropped unless they close the expression
        w_push     = w_take && (w_in.op != pee_pkg::OP_NOP || i_end_of_expr);
        w_pop      = i_pop && o_item_valid;
        n_wp       = r_wp ^ w_push;
        n_rp       = r_rp ^ w_pop;
        n_cnt      = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/pee_div.sv -----
// iterative unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module pee_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pee_pkg::DATA_W-1:0]  i_dividend,
    input  logic [pee_pkg::DATA_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pee_pkg::DATA_W-1:0]  o_quot
);

    localparam int DW = pee_pkg::DATA_W;
    localparam int CNTW = $clog2(DW);

    logic [DW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_dvs, n_dvs;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;

    logic [DW:0]     w_shift;
    logic            w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[DW-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits back in DW bits
            n_rem = w_ge ? DW'(w_shift - {1'b0, r_dvs}) : w_shift[DW-1:0];
            n_quo = {r_quo[DW-2:0], w_ge};
            n_cnt = r_cnt + CNTW'(1);
            if (r_cnt == CNTW'(DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ----- rtl/pee_back.sv -----
// back end: operand stack, arithmetic and result register
`timescale 1ns / 1ps

module pee_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pee_pkg::t_item              i_item,
    input  logic                        i_item_valid,
    output logic                        o_pop,
    output logic                        o_div_start,
    output logic [pee_pkg::DATA_W-1:0]  o_dividend,
    output logic [pee_pkg::DATA_W-1:0]  o_divisor,
    input  logic                        i_div_done,
    input  logic [pee_pkg::DATA_W-1:0]  i_quot,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [pee_pkg::DATA_W-1:0]  o_value,
    output logic [1:0]                  o_status
);

    localparam int DW = pee_pkg::DATA_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    pee_pkg::t_status r_err, n_err;
    pee_pkg::t_op     r_op, n_op;
    logic             r_last, n_last;
    logic             r_neg, n_neg;
    logic [DW-1:0]    r_top, n_top;
    logic             r_out_valid, n_out_valid;
    logic [DW-1:0]    r_value, n_value;
    pee_pkg::t_status r_status, n_status;

    logic             w_we;
    logic [CW-1:0]    w_cm1;
    logic [CW-1:0]    w_cm2;
    logic [DW-1:0]    w_lhs;
    logic [DW-1:0]    w_rhs;

    // the top of stack lives in r_top, the entries below it in the ram
    pee_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_cm1[AW-1:0]),
        .i_wdata (r_top),
        .i_raddr (w_cm2[AW-1:0]),
        .o_rdata (w_lhs)
    );

    assign w_cm1       = r_count - CW'(1);
    assign w_cm2       = r_count - CW'(2);
    assign w_rhs       = r_top;
    assign o_pop       = (r_state == S_IDLE) && i_item_valid;
    assign o_dividend  = w_lhs[DW-1] ? (DW'(0) - w_lhs) : w_lhs;
    assign o_divisor   = w_rhs[DW-1] ? (DW'(0) - w_rhs) : w_rhs;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_op        = r_op;
        n_last      = r_last;
        n_neg       = r_neg;
        n_top       = r_top;
        n_out_valid = r_out_valid && i_stall;
        n_value     = r_value;
        n_status    = r_status;
        w_we        = 1'b0;
        o_div_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_op   = i_item.op;
                    n_last = i_item.last;
                    // after an error the rest of the expression is skipped
                    if (r_err == pee_pkg::ST_OK) begin
                        unique case (i_item.op)
                            pee_pkg::OP_PUSH: begin
                                if (r_count >= CW'(STACK_DEPTH)) begin
                                    n_err = pee_pkg::ST_OVERFLOW;
                                end else begin
                                    w_we    = (r_count != '0);
                                    n_top   = {{(DW - pee_pkg::DIGIT_W){1'b0}}, i_item.digit};
                                    n_count = r_count + CW'(1);
                                end
                            end
                            pee_pkg::OP_ADD, pee_pkg::OP_SUB,
                            pee_pkg::OP_MUL, pee_pkg::OP_DIV: begin
                                if (r_count < CW'(2)) begin
                                    n_err = pee_pkg::ST_UNDERFLOW;
                                end else begin
                                    n_state = S_READ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (n_state == S_IDLE && i_item.last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_READ: begin
                n_state = r_last ? S_FIN : S_IDLE;
                unique case (r_op)
                    pee_pkg::OP_ADD: begin
                        n_top   = w_lhs + w_rhs;
                        n_count = w_cm1;
                    end
                    pee_pkg::OP_SUB: begin
                        n_top   = w_lhs - w_rhs;
                        n_count = w_cm1;
                    end
                    pee_pkg::OP_MUL: begin
                        n_top   = w_lhs * w_rhs;
                        n_count = w_cm1;
                    end
                    pee_pkg::OP_DIV: begin
                        if (w_rhs == '0) begin
                            n_err = pee_pkg::ST_DIVZERO;
                        end else begin
                            o_div_start = 1'b1;
                            n_neg       = w_lhs[DW-1] ^ w_rhs[DW-1];
                            n_state     = S_DIV;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                if (i_div_done) begin
                    // most negative over minus one wraps back to itself here
                    n_top   = r_neg ? (DW'(0) - i_quot) : i_quot;
                    n_count = w_cm1;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    if (r_err != pee_pkg::ST_OK) begin
                        n_status = r_err;
                        n_value  = '0;
                    end else if (r_count == '0) begin
                        n_status = pee_pkg::ST_UNDERFLOW;
                        n_value  = '0;
                    end else begin
                        n_status = pee_pkg::ST_OK;
                        n_value  = r_top;
                    end
                    n_count = '0;
                    n_err   = pee_pkg::ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_last   <= n_last;
        r_neg    <= n_neg;
        r_top    <= n_top;
        r_value  <= n_value;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= pee_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

endmodule

// ----- dv/pee_result_checker.sv -----
// checker for the postfix evaluator: predicts each expression result and compares it
`timescale 1ns / 1ps

module pee_result_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_char_valid,
    input  logic               i_char_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_end_of_expr,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic signed [31:0] i_res_value,
    input  logic [1:0]         i_res_status,
    output int                 o_mismatches,
    output int                 o_outstanding
);

    typedef struct {
        logic [31:0]      value;
        pee_pkg::t_status status;
    } t_expr_result;

    logic [31:0]      operand_stack [STACK_DEPTH];
    int unsigned      stack_fill;
    pee_pkg::t_status first_error;
    t_expr_result     pending_results [$];
    int               mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100) begin
            $display("mismatch at %0t: %s: got %0d, expected %0d",
                     $time, what, $signed(got), $signed(want));
        end
        mismatch_count++;
    endtask

    // one character applied to the predicted stack
    function automatic void evaluate_char(input logic [7:0] c);
        logic [31:0] rhs;
        logic [31:0] lhs;
        logic [31:0] res;
        logic [31:0] num_mag;
        logic [31:0] den_mag;
        logic [31:0] quo;
        if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) begin
            if (stack_fill >= STACK_DEPTH) begin
                first_error = pee_pkg::ST_OVERFLOW;
            end else begin
                operand_stack[stack_fill] = 32'(c - pee_pkg::CH_ZERO);
                stack_fill++;
            end
            return;
        end
        if (!(c inside {pee_pkg::CH_PLUS, pee_pkg::CH_MINUS,
                        pee_pkg::CH_STAR, pee_pkg::CH_SLASH})) return;
        if (stack_fill < 2) begin
            first_error = pee_pkg::ST_UNDERFLOW;
            return;
        end
        rhs = operand_stack[stack_fill - 1];
        lhs = operand_stack[stack_fill - 2];
        case (c)
            pee_pkg::CH_PLUS:  res = lhs + rhs;
            pee_pkg::CH_MINUS: res = lhs - rhs;
            pee_pkg::CH_STAR:  res = lhs * rhs;
            default: begin
                if (rhs == '0) begin
                    first_error = pee_pkg::ST_DIVZERO;
                    return;
                end
                // divide magnitudes, then restore the sign: truncates toward zero
                num_mag = lhs[31] ? -lhs : lhs;
                den_mag = rhs[31] ? -rhs : rhs;
                quo     = num_mag / den_mag;
                res     = (lhs[31] ^ rhs[31]) ? -quo : quo;
            end
        endcase
        stack_fill--;
        operand_stack[stack_fill - 1] = res;
    endfunction

    always @(posedge i_clk) begin
        t_expr_result want;
        if (!i_rst_n) begin
            stack_fill  = 0;
            first_error = pee_pkg::ST_OK;
            pending_results.delete();
        end else begin
            if (i_char_valid && !i_char_stall) begin
                if (first_error == pee_pkg::ST_OK) evaluate_char(i_char_code);
                if (i_end_of_expr) begin
                    want.value  = '0;
                    want.status = first_error;
                    if (first_error == pee_pkg::ST_OK) begin
                        if (stack_fill == 0) begin
                            want.status = pee_pkg::ST_UNDERFLOW;
                        end else begin
                            want.value = operand_stack[stack_fill - 1];
                        end
                    end
                    pending_results.push_back(want);
                    stack_fill  = 0;
                    first_error = pee_pkg::ST_OK;
                end
            end
            if (i_res_valid && !i_res_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no expression pending", i_res_value, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_res_value !== want.value) begin
                        report_mismatch("value", i_res_value, want.value);
                    end
                    if (i_res_status !== want.status) begin
                        report_mismatch("status", 32'(i_res_status), 32'(want.status));
                    end
                end
            end
        end
        o_outstanding <= pending_results.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench top for the postfix evaluator: clock, reset, character stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int     STACK_DEPTH   = 64;
    localparam int     RANDOM_CHARS  = 750;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     SETTLE_CYCLES = 60;
    localparam longint CYCLE_LIMIT   = 1_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_char_code;
    logic               i_end_of_expr;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_value;
    logic [1:0]         o_status;

    int     mismatches;
    int     outstanding;
    int     chars_sent = 0;
    longint cycles     = 0;
    bit     hold_req   = 1'b0;
    bit     burst_mode = 1'b0;

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_code   (i_char_code),
        .i_end_of_expr (i_end_of_expr),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_status      (o_status)
    );

    pee_result_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char_valid  (i_valid),
        .i_char_stall  (o_stall),
        .i_char_code   (i_char_code),
        .i_end_of_expr (i_end_of_expr),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_res_value   (o_value),
        .i_res_status  (o_status),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly back to back, sometimes a short gap, now and then a long gap
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return pee_pkg::CH_PLUS;
            1:       return pee_pkg::CH_MINUS;
            2:       return pee_pkg::CH_STAR;
            default: return pee_pkg::CH_SLASH;
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        i_valid       <= 1'b1;
        i_char_code   <= c;
        i_end_of_expr <= last;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        gap = burst_mode ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s, input bit mark_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], mark_last && i == s.len() - 1);
        end
    endtask

    // fill the stack to a given depth, then a few operators
    task automatic send_deep(input int unsigned pushes, input int unsigned ops);
        for (int unsigned i = 0; i < pushes + ops; i++) begin
            send_char(i < pushes ? pee_pkg::CH_ZERO + 8'($urandom_range(0, 9))
                                 : pick_operator(),
                      i == pushes + ops - 1);
        end
    endtask

    // builds 2**31, which wraps to the most negative value, then divides it
    task automatic send_min_quotient();
        send_text("88*8*8*8*8*8*8*8*8*2*", 1'b0);
        if ($urandom_range(0, 1) == 0) begin
            send_text("01-/", 1'b1);
        end else begin
            send_char(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            send_char(pee_pkg::CH_SLASH, 1'b1);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int unsigned run;
        int unsigned hold;
        i_stall <= 1'b0;
        repeat (8) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 12);
                i_stall <= 1'b0;
                repeat (run) @(posedge i_clk);
                hold = pick_gap();
                if (hold != 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int unsigned base;
        int unsigned kind;
        int unsigned len;
        int unsigned depth;
        int unsigned r;
        logic [7:0]  c;
        bit          mid_drained;
        mid_drained = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_char_code   <= '0;
        i_end_of_expr <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: digit extremes, each operator, ignored codes, error paths
        send_text("9", 1'b1);
        send_text("0", 1'b1);
        send_char(8'hFF, 1'b1);       // end mark on an empty stack
        send_text("+5", 1'b1);        // underflow, then the digit is ignored
        send_text("73-", 1'b1);
        send_text("37-", 1'b1);
        send_text("98*", 1'b1);
        send_text("70/", 1'b1);       // divide by zero
        send_char(8'h00, 1'b0);
        send_text("07-2/", 1'b1);     // negative quotient truncates toward zero
        send_text("412+", 1'b1);      // operand left below the top is dropped
        drain();

        // random part; the receiver holds off while the first deep fills go in
        base     = chars_sent;
        hold_req = 1'b1;
        send_deep(STACK_DEPTH, 0);
        send_deep(STACK_DEPTH + 1, 2);
        send_min_quotient();
        while (chars_sent - base < RANDOM_CHARS) begin
            if (!mid_drained && chars_sent - base >= RANDOM_CHARS / 2) begin
                drain();
                mid_drained = 1'b1;
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 72) begin
                // well-formed postfix with the odd ignored character mixed in
                len   = $urandom_range(1, 24);
                depth = 0;
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 6) begin
                        do c = 8'($urandom_range(0, 255));
                        while ((c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) ||
                               (c inside {pee_pkg::CH_PLUS, pee_pkg::CH_MINUS,
                                          pee_pkg::CH_STAR, pee_pkg::CH_SLASH}));
                    end else if (depth >= 2 && r < 50) begin
                        c = pick_operator();
                        depth--;
                    end else begin
                        c = pee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                        depth++;
                    end
                    send_char(c, i == len - 1);
                end
            end else if (kind < 88) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    send_char(8'($urandom_range(0, 255)), i == len - 1);
                end
            end else if (kind < 91) begin
                send_deep($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2),
                          $urandom_range(0, 3));
            end else begin
                send_min_quotient();
            end
        end
        burst_mode = 1'b0;
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
